[hw/rtl/pppm_pkg.sv]
`timescale 1ns / 1ps

package pppm_pkg;

	// fixed field widths
	localparam int PERIOD_W   = 32;
	localparam int MULT_W     = 32;
	localparam int VALUE_W    = 40;
	localparam int SWAP_W     = 16;
	localparam int EDGES_W    = 2;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_POWER_MULT   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_VOLTAGE_MULT = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_MULT = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SWAP_WAIT    = 3'd4;

	// register reset values
	localparam logic [PERIOD_W-1:0] TIMEOUT_RESET   = 32'd2000000;
	localparam logic [SWAP_W-1:0]   SWAP_WAIT_RESET = 16'd1000;

	// edges needed after settling before the shared reading is valid
	localparam logic [EDGES_W-1:0] EDGES_NEEDED = 2'd2;

endpackage

[hw/rtl/pulse_period_power_meter_top.sv]
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: one microsecond tick with edge flags and mode
// m_*       out  m_tvalid/m_tready  m_tdata: readings, m_tuser: select level
// cfg_*     in   cfg_we             cfg_addr, cfg_wdata: register write, no read-back
//
// one bit-serial divider is used twice per item, once for power and once for the
// shared line
// s_tready is high only while the sequencer is idle; a finished item waits in
// the output register, so the next tick can be taken while it is not yet read
// the sequencer holds a result until the output register is free
// arst_n clears the tick counters, periods and flags and loads the register defaults

module pulse_period_power_meter_top
	import pppm_pkg::*;
#(
	parameter int FRAC_BITS    = 8,
	parameter int ENERGY_WIDTH = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// power_edge, shared_edge, want_voltage, clear_energy, zero pad
	input  logic [7:0]            s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// power_value, shared_value, shared_valid, power_period_raw,
	// shared_period_raw, energy_pulses, zero pad
	output logic [((2*VALUE_W+1+2*PERIOD_W+ENERGY_WIDTH+7)/8)*8-1:0] m_tdata,
	// select_voltage
	output logic                  m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DIV_W    = PERIOD_W + FRAC_BITS;
	localparam int OUT_BITS = 2*VALUE_W + 1 + 2*PERIOD_W + ENERGY_WIDTH;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// sequencer codes
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_STARTP = 3'd2;
	localparam logic [2:0] S_WAITP  = 3'd3;
	localparam logic [2:0] S_STARTS = 3'd4;
	localparam logic [2:0] S_WAITS  = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	function automatic logic [PERIOD_W-1:0] sat_inc(input logic [PERIOD_W-1:0] x);
		sat_inc = (x == '1) ? x : x + PERIOD_W'(1);
	endfunction

	// configuration registers
	logic [MULT_W-1:0]   pmult_q;
	logic [MULT_W-1:0]   vmult_q;
	logic [MULT_W-1:0]   cmult_q;
	logic [PERIOD_W-1:0] timeout_q;
	logic [SWAP_W-1:0]   swap_wait_q;

	// tick state
	logic [PERIOD_W-1:0]     page_q;
	logic [PERIOD_W-1:0]     sage_q;
	logic [PERIOD_W-1:0]     pper_q;
	logic [PERIOD_W-1:0]     vper_q;
	logic [PERIOD_W-1:0]     cper_q;
	logic                    mode_q;
	logic [EDGES_W-1:0]      edges_q;
	logic [SWAP_W-1:0]       settle_q;
	logic [ENERGY_WIDTH-1:0] energy_q;

	// snapshot of the readings for the item at work
	logic [PERIOD_W-1:0] praw_q;
	logic [PERIOD_W-1:0] sraw_q;
	logic                valid_q;
	logic [VALUE_W-1:0]  pval_q;

	logic [2:0] state_q;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               m_tuser_q;
	logic               out_load;

	// input fields
	logic in_pedge;
	logic in_sedge;
	logic in_wantv;
	logic in_clr;
	logic accept;

	assign in_pedge = s_tdata[0];
	assign in_sedge = s_tdata[1];
	assign in_wantv = s_tdata[2];
	assign in_clr   = s_tdata[3];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// finished item moves into the output register once it is free
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	// next tick state
	logic                    chg;
	logic [SWAP_W-1:0]       settle_nx;
	logic [EDGES_W-1:0]      edges_base;
	logic [ENERGY_WIDTH-1:0] energy_base;

	assign chg         = in_wantv != mode_q;
	assign settle_nx   = chg ? swap_wait_q :
	                     (settle_q != '0) ? settle_q - SWAP_W'(1) : settle_q;
	assign edges_base  = chg ? '0 : edges_q;
	assign energy_base = in_clr ? '0 : energy_q;

	// readings formed from the state after the tick
	logic                p_stale;
	logic                s_live;
	logic [PERIOD_W-1:0] s_period;

	assign p_stale  = page_q > timeout_q;
	assign s_live   = (edges_q == EDGES_NEEDED) && (settle_q == '0) && (sage_q <= timeout_q);
	assign s_period = mode_q ? vper_q : cper_q;

	// shared divider
	logic                div_start;
	logic [DIV_W-1:0]    div_dividend;
	logic [PERIOD_W-1:0] div_divisor;
	logic                div_done;
	logic [DIV_W-1:0]    div_quo;
	logic [MULT_W-1:0]   div_mult;
	logic [VALUE_W-1:0]  quo_sat;
	logic [VALUE_W-1:0]  quo_final;

	assign div_start    = (state_q == S_STARTP) || (state_q == S_STARTS);
	assign div_mult     = (state_q == S_STARTP) ? pmult_q : (mode_q ? vmult_q : cmult_q);
	assign div_divisor  = (state_q == S_STARTP) ? praw_q : sraw_q;
	assign div_dividend = DIV_W'(div_mult) << FRAC_BITS;

	pppm_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// quotient above the value width saturates to all ones
	generate
		if (DIV_W > VALUE_W) begin : g_sat
			assign quo_sat = (|div_quo[DIV_W-1:VALUE_W]) ? '1 : div_quo[VALUE_W-1:0];
		end else begin : g_nosat
			assign quo_sat = VALUE_W'(div_quo);
		end
	endgenerate

	// a zero period reads as zero
	assign quo_final = (((state_q == S_WAITP) ? praw_q : sraw_q) == '0) ? '0 : quo_sat;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmult_q     <= '0;
			vmult_q     <= '0;
			cmult_q     <= '0;
			timeout_q   <= TIMEOUT_RESET;
			swap_wait_q <= SWAP_WAIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_POWER_MULT:   pmult_q     <= cfg_wdata[MULT_W-1:0];
				REG_VOLTAGE_MULT: vmult_q     <= cfg_wdata[MULT_W-1:0];
				REG_CURRENT_MULT: cmult_q     <= cfg_wdata[MULT_W-1:0];
				REG_TIMEOUT:      timeout_q   <= cfg_wdata[PERIOD_W-1:0];
				REG_SWAP_WAIT:    swap_wait_q <= cfg_wdata[SWAP_W-1:0];
				default: ;
			endcase
		end
	end

	// tick state update on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q   <= '0;
			sage_q   <= '0;
			pper_q   <= '0;
			vper_q   <= '0;
			cper_q   <= '0;
			mode_q   <= 1'b0;
			edges_q  <= '0;
			settle_q <= '0;
			energy_q <= '0;
		end else if (accept) begin
			mode_q   <= in_wantv;
			settle_q <= settle_nx;
			if (in_pedge) begin
				pper_q   <= sat_inc(page_q);
				page_q   <= '0;
				energy_q <= energy_base + ENERGY_WIDTH'(1);
			end else begin
				page_q   <= sat_inc(page_q);
				energy_q <= energy_base;
			end
			if (in_sedge) begin
				if (in_wantv) begin
					vper_q <= sat_inc(sage_q);
				end else begin
					cper_q <= sat_inc(sage_q);
				end
				sage_q <= '0;
				// edges during settling do not count
				if ((settle_nx == '0) && (edges_base < EDGES_NEEDED)) begin
					edges_q <= edges_base + EDGES_W'(1);
				end else begin
					edges_q <= edges_base;
				end
			end else begin
				sage_q  <= sat_inc(sage_q);
				edges_q <= edges_base;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL:   state_q <= S_STARTP;
				S_STARTP: state_q <= S_WAITP;
				S_WAITP: begin
					if (div_done) begin
						state_q <= S_STARTS;
					end
				end
				S_STARTS: state_q <= S_WAITS;
				S_WAITS: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold the item until the output register is free
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// readings and output payload
	logic [VALUE_W-1:0] sval_q;

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			praw_q  <= p_stale ? '0 : pper_q;
			sraw_q  <= s_live ? s_period : '0;
			valid_q <= s_live;
		end
		if ((state_q == S_WAITP) && div_done) begin
			pval_q <= quo_final;
		end
		if ((state_q == S_WAITS) && div_done) begin
			sval_q <= quo_final;
		end
		if (out_load) begin
			m_tdata_q <= OUT_W'({energy_q, sraw_q, praw_q, valid_q, sval_q, pval_q});
			m_tuser_q <= mode_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[hw/rtl/pppm_div.sv]
`timescale 1ns / 1ps

module pppm_div
	import pppm_pkg::*;
#(
	parameter int DIV_W = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_W-1:0]    dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output logic                done,
	output logic [DIV_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] den_q;
	logic [DIV_W-1:0]    quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic                ge;
	logic [PERIOD_W-1:0] rem_nx;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial  = {rem_q, quo_q[DIV_W-1]};
	assign ge     = trial >= {1'b0, den_q};
	assign diff   = trial - {1'b0, den_q};
	assign rem_nx = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[test/pulse_period_power_meter_checker.sv]
`timescale 1ns / 1ps

module pulse_period_power_meter_checker
	import pppm_pkg::*;
#(
	parameter int FRAC_BITS    = 8,
	parameter int ENERGY_WIDTH = 48,
	parameter int TDATA_W      = 200
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [TDATA_W-1:0]    m_tdata,
	input  logic                  m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    readings_due
);

	// tick fields
	localparam int BIT_POWER_EDGE  = 0;
	localparam int BIT_SHARED_EDGE = 1;
	localparam int BIT_WANT_VOLT   = 2;
	localparam int BIT_CLEAR       = 3;

	// reading fields
	localparam int SHARED_LO = VALUE_W;
	localparam int VALID_BIT = 2*VALUE_W;
	localparam int PRAW_LO   = VALID_BIT + 1;
	localparam int SRAW_LO   = PRAW_LO + PERIOD_W;
	localparam int ENERGY_LO = SRAW_LO + PERIOD_W;

	typedef struct packed {
		logic [VALUE_W-1:0]      power_value;
		logic [VALUE_W-1:0]      shared_value;
		logic                    select_voltage;
		logic                    shared_valid;
		logic [PERIOD_W-1:0]     power_period_raw;
		logic [PERIOD_W-1:0]     shared_period_raw;
		logic [ENERGY_WIDTH-1:0] energy_pulses;
	} reading_t;

	// register copies
	logic [MULT_W-1:0]   pwr_mult, volt_mult, curr_mult;
	logic [PERIOD_W-1:0] stale_limit;
	logic [SWAP_W-1:0]   settle_ticks;

	// meter state
	logic [PERIOD_W-1:0]     pwr_age, sh_age, pwr_period, volt_period, curr_period;
	logic                    in_volt_mode;
	logic [EDGES_W-1:0]      edge_count;
	logic [SWAP_W-1:0]       settle_cnt;
	logic [ENERGY_WIDTH-1:0] pulse_count;

	reading_t expected_q[$];
	reading_t oldest;
	int       ticks_taken;
	int       readings_checked;

	assign readings_due = ticks_taken - readings_checked;

	function automatic logic [PERIOD_W-1:0] age_up(logic [PERIOD_W-1:0] x);
		return (x == '1) ? x : x + 1'b1;
	endfunction

	function automatic logic [VALUE_W-1:0] scale_reading(logic [MULT_W-1:0] m,
			logic [PERIOD_W-1:0] per);
		logic [63:0] q;
		if (per == '0)
			return '0;
		q = ({32'b0, m} << FRAC_BITS) / {32'b0, per};
		return (q > {{(64-VALUE_W){1'b0}}, {VALUE_W{1'b1}}}) ? '1 : q[VALUE_W-1:0];
	endfunction

	// advance the meter by one tick and form its reading
	function automatic reading_t advance_meter(logic [7:0] t);
		reading_t r;
		logic [PERIOD_W-1:0] p_raw, s_raw;
		logic [MULT_W-1:0]   s_mult;
		logic                live;
		if (t[BIT_CLEAR])
			pulse_count = '0;
		if (t[BIT_WANT_VOLT] != in_volt_mode) begin
			in_volt_mode = t[BIT_WANT_VOLT];
			settle_cnt = settle_ticks;
			edge_count = '0;
		end else if (settle_cnt != '0) begin
			settle_cnt = settle_cnt - 1'b1;
		end
		if (t[BIT_POWER_EDGE]) begin
			pwr_period = age_up(pwr_age);
			pwr_age = '0;
			pulse_count = pulse_count + 1'b1;
		end else begin
			pwr_age = age_up(pwr_age);
		end
		if (t[BIT_SHARED_EDGE]) begin
			if (in_volt_mode)
				volt_period = age_up(sh_age);
			else
				curr_period = age_up(sh_age);
			sh_age = '0;
			if (settle_cnt == '0 && edge_count < EDGES_NEEDED)
				edge_count = edge_count + 1'b1;
		end else begin
			sh_age = age_up(sh_age);
		end
		p_raw = (pwr_age > stale_limit) ? '0 : pwr_period;
		live = (edge_count == EDGES_NEEDED) && (settle_cnt == '0) && (sh_age <= stale_limit);
		s_raw = in_volt_mode ? volt_period : curr_period;
		s_mult = in_volt_mode ? volt_mult : curr_mult;
		if (!live)
			s_raw = '0;
		r.power_value = scale_reading(pwr_mult, p_raw);
		r.shared_value = scale_reading(s_mult, s_raw);
		r.select_voltage = in_volt_mode;
		r.shared_valid = live;
		r.power_period_raw = p_raw;
		r.shared_period_raw = s_raw;
		r.energy_pulses = pulse_count;
		return r;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("reading %0d %s: expected %h, got %h",
					readings_checked, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwr_mult = '0;
			volt_mult = '0;
			curr_mult = '0;
			stale_limit = TIMEOUT_RESET;
			settle_ticks = SWAP_WAIT_RESET;
			pwr_age = '0;
			sh_age = '0;
			pwr_period = '0;
			volt_period = '0;
			curr_period = '0;
			in_volt_mode = 1'b0;
			edge_count = '0;
			settle_cnt = '0;
			pulse_count = '0;
			mismatches = 0;
			expected_q.delete();
			ticks_taken <= 0;
			readings_checked <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_POWER_MULT:   pwr_mult = cfg_wdata;
					REG_VOLTAGE_MULT: volt_mult = cfg_wdata;
					REG_CURRENT_MULT: curr_mult = cfg_wdata;
					REG_TIMEOUT:      stale_limit = cfg_wdata;
					REG_SWAP_WAIT:    settle_ticks = cfg_wdata[SWAP_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(advance_meter(s_tdata));
				ticks_taken <= ticks_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("reading %0d arrived with no tick pending", readings_checked);
					mismatches++;
				end else begin
					oldest = expected_q.pop_front();
					compare_field("power_value", oldest.power_value,
						m_tdata[VALUE_W-1:0]);
					compare_field("shared_value", oldest.shared_value,
						m_tdata[SHARED_LO +: VALUE_W]);
					compare_field("select_voltage", oldest.select_voltage, m_tuser);
					compare_field("shared_valid", oldest.shared_valid, m_tdata[VALID_BIT]);
					compare_field("power_period_raw", oldest.power_period_raw,
						m_tdata[PRAW_LO +: PERIOD_W]);
					compare_field("shared_period_raw", oldest.shared_period_raw,
						m_tdata[SRAW_LO +: PERIOD_W]);
					compare_field("energy_pulses", oldest.energy_pulses,
						m_tdata[ENERGY_LO +: ENERGY_WIDTH]);
				end
				readings_checked <= readings_checked + 1;
			end
		end
	end

endmodule

[test/pulse_period_power_meter_top_test.sv]
`timescale 1ns / 1ps

module pulse_period_power_meter_top_test;
	import pppm_pkg::*;

	localparam int FRAC_BITS    = 8;
	localparam int ENERGY_WIDTH = 48;
	localparam int TDATA_W      = ((2*VALUE_W+1+2*PERIOD_W+ENERGY_WIDTH+7)/8)*8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 2500;
	localparam int PHASES       = 6;
	localparam int PHASE_TICKS  = 75;

	// no register lives at this index, writes to it must change nothing
	localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// power_edge, shared_edge, want_voltage, clear_energy, zero pad
	logic [7:0]            s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// power_value, shared_value, shared_valid, power_period_raw,
	// shared_period_raw, energy_pulses, zero pad
	logic [TDATA_W-1:0]    m_tdata;
	// select_voltage
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int mismatches;
	int readings_due;
	int cycles = 0;

	// traffic shaping flags, all changed with nonblocking writes at the clock edge
	logic steady = 1'b0;     // no idling on either side
	logic stall_req = 1'b0;  // asks the receiver for one long hold-off
	logic hold = 1'b0;

	always #2 clk = ~clk;

	pulse_period_power_meter_top #(
		.FRAC_BITS(FRAC_BITS),
		.ENERGY_WIDTH(ENERGY_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	pulse_period_power_meter_checker #(
		.FRAC_BITS(FRAC_BITS),
		.ENERGY_WIDTH(ENERGY_WIDTH),
		.TDATA_W(TDATA_W)
	) meter_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.readings_due(readings_due)
	);

	// watchdog, well beyond the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random back-pressure, none while steady, nothing during the hold-off
	always @(posedge clk) begin
		m_tready <= !hold && (steady || $urandom_range(99) >= 15);
	end

	// one long hold-off so the output register fills and s_tready drops
	initial begin
		@(posedge clk);
		while (!stall_req)
			@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold <= 1'b0;
	end

	function automatic logic [7:0] tick_bits(bit p, bit s, bit v, bit c);
		return {4'b0, c, v, s, p};
	endfunction

	// offer one tick, with random gaps before it, and wait for the handshake
	task automatic send_tick(logic [7:0] t);
		while (!steady && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// stop offering and wait until every reading is back, the meter is then idle
	task automatic drain;
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (readings_due != 0);
	endtask

	// one register write per cycle, caller lowers cfg_we afterwards
	task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(posedge clk);
	endtask

	task automatic program_meter(logic [31:0] pm, logic [31:0] vm, logic [31:0] cm,
			logic [31:0] tmo, logic [15:0] sw);
		write_reg(REG_POWER_MULT, pm);
		write_reg(REG_VOLTAGE_MULT, vm);
		write_reg(REG_CURRENT_MULT, cm);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_SWAP_WAIT, {16'b0, sw});
		cfg_we <= 1'b0;
	endtask

	// multipliers: extremes half the time, anything otherwise
	function automatic logic [31:0] pick_mult();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int p_rate, s_rate, flip_rate;
		bit want_v;
		logic [31:0] tmo;
		logic [15:0] sw;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: first edges measured from tick zero, multipliers still zero
		send_tick(tick_bits(0, 0, 0, 0));
		send_tick(tick_bits(1, 0, 0, 0));
		send_tick(tick_bits(0, 1, 0, 0));
		send_tick(tick_bits(0, 1, 0, 0));
		drain();

		// full-scale power and voltage multipliers, short timeout and settle, plus a write to no register
		write_reg(REG_UNMAPPED, $urandom);
		program_meter('1, '1, 32'd1, 32'd3, 16'd2);
		send_tick(tick_bits(1, 1, 0, 0));
		// power line goes stale once its age passes the timeout
		repeat (5) send_tick(tick_bits(0, 0, 0, 0));
		// switch to voltage, edges while settling do not count
		send_tick(tick_bits(0, 1, 1, 0));
		send_tick(tick_bits(0, 1, 1, 0));
		send_tick(tick_bits(0, 1, 1, 0));
		// back and forth restarts the settle time
		send_tick(tick_bits(0, 0, 0, 0));
		send_tick(tick_bits(0, 0, 1, 0));
		repeat (4) send_tick(tick_bits(0, 1, 1, 0));
		// energy clear alone and together with a power edge
		send_tick(tick_bits(1, 0, 1, 1));
		send_tick(tick_bits(0, 0, 1, 1));
		send_tick(tick_bits(1, 1, 1, 1));
		drain();

		// zero timeout: a reading lives only on the tick of its edge
		program_meter(32'd1, 32'h8000_0000, '1, 32'd0, 16'd0);
		send_tick(tick_bits(1, 1, 1, 0));
		send_tick(tick_bits(0, 0, 1, 0));
		send_tick(tick_bits(1, 1, 1, 0));
		send_tick(tick_bits(0, 1, 1, 0));
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: tmo = 32'd1;
				1: tmo = '1;
				default: tmo = $urandom_range(40, 2);
			endcase
			case (ph)
				2: sw = 16'hFFFF;
				3: sw = 16'd0;
				default: sw = 16'($urandom_range(6, 0));
			endcase
			program_meter(pick_mult(), pick_mult(), pick_mult(), tmo, sw);
			steady <= (ph == 4);
			if (ph == 1)
				stall_req <= 1'b1;
			p_rate = $urandom_range(60, 10);
			s_rate = $urandom_range(60, 10);
			flip_rate = $urandom_range(8, 2);
			want_v = 1'($urandom_range(1));
			for (int i = 0; i < PHASE_TICKS; i++) begin
				if ($urandom_range(99) < 10) begin
					// noise: any combination, mode flips included
					send_tick(tick_bits(1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)), 1'($urandom_range(1))));
				end else begin
					// mode held between rare flips, long enough to settle and collect edges unless the settle time is 16'hFFFF
					if ($urandom_range(99) < flip_rate)
						want_v = !want_v;
					send_tick(tick_bits($urandom_range(99) < p_rate,
						$urandom_range(99) < s_rate, want_v, $urandom_range(99) < 3));
				end
			end
			drain();
		end
		steady <= 1'b0;

		// let any late stray reading show up before the verdict
		repeat (200) @(posedge clk);
		if (mismatches == 0 && readings_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/pppm_pkg.sv
hw/rtl/pppm_div.sv
hw/rtl/pulse_period_power_meter_top.sv
test/pulse_period_power_meter_checker.sv
test/pulse_period_power_meter_top_test.sv
